@@ design/seven_bit_character_histogram_top_defines.svh @@
// Assertion macros used by the character histogram top level.
`ifndef SEVEN_BIT_CHARACTER_HISTOGRAM_TOP_DEFINES_SVH
`define SEVEN_BIT_CHARACTER_HISTOGRAM_TOP_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define SBCH_ASSERT_SAME(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define SBCH_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/sbch_pkg.sv @@
// Shared constants, types and helper functions of the character histogram.
package sbch_pkg;

    // Table size and counter width.
    localparam int BIN_COUNT   = 128;
    localparam int COUNT_WIDTH = 32;
    localparam int BIN_AW      = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
    localparam int CODE_W      = 7;
    localparam int OUT_W       = 32;

    // Mask that strips the top bit of an input byte.
    localparam logic [7:0] CODE_MASK = 8'o177;

    // Item kinds carried on tuser.
    localparam logic [1:0] KIND_COUNT    = 2'd0;
    localparam logic [1:0] KIND_READ     = 2'd1;
    localparam logic [1:0] KIND_NEW_FILE = 2'd2;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [BIN_AW-1:0]      bin_addr_t;
    typedef logic [OUT_W-1:0]       out_t;

    // Control group from the sequencer to one bin table.
    typedef struct packed {
        logic rd_en;
        logic inc_en;
        logic clear;
    } bin_ctrl_t;

    // Increment that sticks at the counter's maximum.
    function automatic count_t sat_inc(input count_t v);
        return (v == '1) ? v : v + count_t'(1);
    endfunction

    // Clamp a counter to the 32-bit output field.
    function automatic out_t clamp_out(input count_t v);
        return (v > count_t'(32'hFFFF_FFFF)) ? '1 : OUT_W'(v);
    endfunction

endpackage

@@ design/seven_bit_character_histogram_top.sv @@
// Top level of the seven-bit character histogram.
//
//  Port group  Dir  Contents
//  s_*         in   word: tdata = char_byte, bin_index; tuser = kind
//  m_*         out  word: tdata = file_bin, total_bin, file_char, all_char counts
//
// Each item passes through the IDLE and EXEC states: the accept cycle in IDLE issues the bin
// RAM reads, and EXEC applies the update or loads the result from the registered RAM data.
// A read item waits in EXEC while the output register still holds an untaken
// result. Reset clears the valid bits of both tables at once, so no clearing
// pass is needed. A new-file item drops all per-file valid bits at once.
`include "seven_bit_character_histogram_top_defines.svh"
module seven_bit_character_histogram_top import sbch_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // [7:0] char_byte, [14:8] bin_index, [15] zero
    input  logic [1:0]   s_tuser,   // [1:0] kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // [31:0] file_bin_count, [63:32] total_bin_count,
                                    // [95:64] file_char_count, [127:96] all_char_count
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic              state_reg, state_next;
    logic [1:0]        kind_reg;
    logic              hit_reg;
    count_t            file_chars_reg, file_chars_next;
    count_t            all_chars_reg, all_chars_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [127:0]      m_tdata_reg;

    logic              accept;
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] sel_idx;
    logic              done;
    logic              load_out;
    bin_ctrl_t         file_ctrl, total_ctrl;
    count_t            file_count, total_count;
    out_t              file_out, total_out;

    // Input decode: strip the top bit and pick the bin to address.
    assign accept   = s_tvalid && s_tready;
    assign code     = CODE_W'(s_tdata[7:0] & CODE_MASK);
    assign sel_idx  = (s_tuser == KIND_READ) ? s_tdata[14:8] : code;
    assign s_tready = (state_reg == ST_IDLE);

    // The EXEC state finishes unless a read result has nowhere to go.
    assign done     = (state_reg == ST_EXEC) &&
                      !((kind_reg == KIND_READ) && m_tvalid_reg && !m_tready);
    assign load_out = done && (kind_reg == KIND_READ);

    // Table control.
    always_comb begin
        file_ctrl.rd_en   = accept;
        file_ctrl.inc_en  = done && (kind_reg == KIND_COUNT) && hit_reg;
        file_ctrl.clear   = done && (kind_reg == KIND_NEW_FILE);
        total_ctrl.rd_en  = accept;
        total_ctrl.inc_en = done && (kind_reg == KIND_COUNT) && hit_reg;
        total_ctrl.clear  = 1'b0;
    end

    sbch_bins u_file_bins (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (file_ctrl),
        .rd_addr (BIN_AW'(sel_idx)),
        .count   (file_count)
    );

    sbch_bins u_total_bins (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (total_ctrl),
        .rd_addr (BIN_AW'(sel_idx)),
        .count   (total_count)
    );

    // Item registers captured at accept.
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg <= s_tuser;
            hit_reg  <= (32'(sel_idx) < BIN_COUNT);
        end
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Character counters.
    always_comb begin
        file_chars_next = file_chars_reg;
        all_chars_next  = all_chars_reg;
        if (done) begin
            case (kind_reg)
                KIND_COUNT: begin
                    file_chars_next = sat_inc(file_chars_reg);
                    all_chars_next  = sat_inc(all_chars_reg);
                end
                KIND_NEW_FILE: begin
                    file_chars_next = '0;
                end
                default: ;
            endcase
        end
    end

    // Output register.
    assign file_out  = hit_reg ? clamp_out(file_count) : '0;
    assign total_out = hit_reg ? clamp_out(total_count) : '0;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata_reg <= {clamp_out(all_chars_reg), clamp_out(file_chars_reg),
                            total_out, file_out};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            file_chars_reg <= '0;
            all_chars_reg  <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            file_chars_reg <= file_chars_next;
            all_chars_reg  <= all_chars_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks on the sequencer and counters.
    `SBCH_ASSERT_NEXT(a_accept_enters_exec, aclk, aresetn, accept, state_reg == ST_EXEC, "accepted word did not enter the update cycle")
    `SBCH_ASSERT_SAME(a_totals_cover_file, aclk, aresetn, 1'b1, all_chars_reg >= file_chars_reg, "file character count exceeds grand count")
    `SBCH_ASSERT_NEXT(a_new_file_clears, aclk, aresetn, done && (kind_reg == KIND_NEW_FILE), file_chars_reg == '0, "new file did not clear the file character count")

endmodule

@@ design/sbch_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
module sbch_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/sbch_bins.sv @@
// One table of saturating bin counters: RAM, valid bits and read-modify-write.
module sbch_bins import sbch_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  bin_ctrl_t ctrl,
    input  bin_addr_t rd_addr,
    output count_t    count
);

    bin_addr_t              addr_reg;
    logic [BIN_COUNT-1:0]   valid_reg;
    logic [BIN_COUNT-1:0]   valid_next;
    count_t                 rd_data;

    // Hold the address of the entry under work for the write-back.
    always_ff @(posedge aclk) begin
        if (ctrl.rd_en) begin
            addr_reg <= rd_addr;
        end
    end

    sbch_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (BIN_COUNT),
        .AW    (BIN_AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ctrl.inc_en),
        .wr_addr (addr_reg),
        .wr_data (sat_inc(count)),
        .rd_en   (ctrl.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // An entry never written since the last clear reads as zero.
    assign count = valid_reg[addr_reg] ? rd_data : '0;

    // Valid bits: a clear drops them all, a write-back sets one.
    always_comb begin
        valid_next = valid_reg;
        if (ctrl.clear) begin
            valid_next = '0;
        end else if (ctrl.inc_en) begin
            valid_next[addr_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

endmodule

@@ dv/seven_bit_character_histogram_top_tb.sv @@
// Self-checking testbench for the seven-bit character histogram top level.
`timescale 1ns / 1ps

module seven_bit_character_histogram_top_tb import sbch_pkg::*;;

    // Kind code that the block must ignore.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int RESULT_W     = 4 * OUT_W;
    localparam int RESET_CYCLES = 6;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int QUIET_LIMIT  = 5000;
    localparam int REPORT_LIMIT = 10;

    // Running histogram and the queue of read results still owed by the block.
    class histogram_scoreboard;
        count_t      file_bins [BIN_COUNT];
        count_t      total_bins [BIN_COUNT];
        count_t      file_chars;
        count_t      all_chars;
        logic [RESULT_W-1:0] owed_reads [$];
        int          mismatches;
        string       field_name [4] = '{"file_bin_count", "total_bin_count",
                                        "file_char_count", "all_char_count"};

        function new();
            foreach (file_bins[i]) begin
                file_bins[i]  = '0;
                total_bins[i] = '0;
            end
            file_chars = '0;
            all_chars  = '0;
            mismatches = 0;
        endfunction

        // Counters stick at all ones instead of wrapping.
        function count_t bump(input count_t v);
            return (&v) ? v : v + count_t'(1);
        endfunction

        // A counter wider than the output field reads as the field's maximum.
        function out_t to_field(input count_t v);
            if (COUNT_WIDTH > OUT_W && v > count_t'({OUT_W{1'b1}}))
                return '1;
            return out_t'(v);
        endfunction

        // Apply one accepted word to the histogram.
        function void note_input(input logic [1:0] kind, input logic [7:0] ch,
                                 input logic [CODE_W-1:0] idx);
            logic [CODE_W-1:0] code;
            out_t fb;
            out_t tb;
            code = ch[CODE_W-1:0];
            case (kind)
                KIND_COUNT: begin
                    if (int'(code) < BIN_COUNT) begin
                        file_bins[code]  = bump(file_bins[code]);
                        total_bins[code] = bump(total_bins[code]);
                    end
                    file_chars = bump(file_chars);
                    all_chars  = bump(all_chars);
                end
                KIND_READ: begin
                    fb = '0;
                    tb = '0;
                    if (int'(idx) < BIN_COUNT) begin
                        fb = to_field(file_bins[idx]);
                        tb = to_field(total_bins[idx]);
                    end
                    owed_reads.push_back({to_field(all_chars), to_field(file_chars), tb, fb});
                end
                KIND_NEW_FILE: begin
                    foreach (file_bins[i]) file_bins[i] = '0;
                    file_chars = '0;
                end
                default: ;
            endcase
        endfunction

        // Compare a result word with the oldest owed read, field by field.
        function void check_result(input logic [RESULT_W-1:0] got);
            logic [RESULT_W-1:0] want;
            if (owed_reads.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result word %h at %0t", got, $realtime);
                return;
            end
            want = owed_reads.pop_front();
            for (int f = 0; f < 4; f++) begin
                if (got[f*OUT_W +: OUT_W] !== want[f*OUT_W +: OUT_W]) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%s mismatch at %0t: expected %0d, got %0d",
                                 field_name[f], $realtime,
                                 want[f*OUT_W +: OUT_W], got[f*OUT_W +: OUT_W]);
                end
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [15:0]          s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [RESULT_W-1:0]  m_tdata;

    histogram_scoreboard hist = new();

    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int quiet_cycles  = 0;

    seven_bit_character_histogram_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Drive one word, with random idle cycles ahead of it, and wait until it is taken.
    task automatic send_word(input logic [1:0] kind, input logic [7:0] ch,
                             input logic [CODE_W-1:0] idx);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = {1'b0, idx, ch};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        hist.note_input(kind, ch, idx);
        @(negedge aclk);
    endtask

    // Edge values of every field, every kind, forwarding hazards and file restarts.
    task automatic directed_items();
        send_word(KIND_READ,     8'h00, 7'h00);
        send_word(KIND_READ,     8'hFF, 7'h7F);
        send_word(KIND_COUNT,    8'h00, 7'h7F);
        send_word(KIND_COUNT,    8'h7F, 7'h00);
        send_word(KIND_COUNT,    8'h80, 7'h55);
        send_word(KIND_COUNT,    8'hFF, 7'h2A);
        send_word(KIND_COUNT,    8'h41, 7'h00);
        send_word(KIND_READ,     8'h00, 7'h00);
        send_word(KIND_READ,     8'h80, 7'h7F);
        send_word(KIND_READ,     8'h7F, 7'h41);
        // Ignored kind must leave every count alone.
        send_word(KIND_UNUSED,   8'hFF, 7'h7F);
        send_word(KIND_UNUSED,   8'h00, 7'h00);
        send_word(KIND_READ,     8'hAA, 7'h7F);
        // New file clears per-file counts only.
        send_word(KIND_NEW_FILE, 8'hFF, 7'h7F);
        send_word(KIND_READ,     8'h00, 7'h00);
        send_word(KIND_READ,     8'h00, 7'h7F);
        // Back-to-back hits on one bin, then an immediate read of it.
        send_word(KIND_COUNT,    8'h55, 7'h00);
        send_word(KIND_COUNT,    8'hD5, 7'h00);
        send_word(KIND_COUNT,    8'h55, 7'h00);
        send_word(KIND_READ,     8'h00, 7'h55);
        send_word(KIND_COUNT,    8'hD5, 7'h55);
        send_word(KIND_READ,     8'h55, 7'h55);
        // Read right behind a new-file word.
        send_word(KIND_NEW_FILE, 8'h00, 7'h00);
        send_word(KIND_READ,     8'h00, 7'h55);
        send_word(KIND_READ,     8'hFF, 7'h41);
    endtask

    // Random words, biased toward a few hot codes so bins collide often.
    task automatic random_items(input int n);
        logic [CODE_W-1:0] hot [4];
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] idx;
        logic [1:0]        kind;
        int                pick;
        foreach (hot[i]) hot[i] = CODE_W'($urandom_range(0, 127));
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 49) == 0)
                hot[$urandom_range(0, 3)] = CODE_W'($urandom_range(0, 127));
            code = ($urandom_range(0, 3) != 0) ? hot[$urandom_range(0, 3)]
                                               : CODE_W'($urandom_range(0, 127));
            idx  = ($urandom_range(0, 3) != 0) ? hot[$urandom_range(0, 3)]
                                               : CODE_W'($urandom_range(0, 127));
            pick = $urandom_range(0, 99);
            if (pick < 58)
                kind = KIND_COUNT;
            else if (pick < 90)
                kind = KIND_READ;
            else if (pick < 95)
                kind = KIND_NEW_FILE;
            else
                kind = KIND_UNUSED;
            send_word(kind, {1'($urandom_range(0, 1)), code}, idx);
        end
    endtask

    // Result side: random backpressure, plus a long hold whenever one is requested.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (holds_served < hold_requests) begin
                m_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                holds_served++;
            end
            m_tready = aresetn && ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Check every result word taken.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            hist.check_result(m_tdata);
    end

    // Watchdog on cycles with no handshake on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Reset, then the stimulus phases, then drain and verdict.
    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = KIND_COUNT;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        tx_idle_pct = 24;
        rx_idle_pct = 73;
        directed_items();
        random_items(420);

        tx_idle_pct = 73;
        rx_idle_pct = 24;
        random_items(420);

        // Hold the result side while reads keep arriving, so the input stalls.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_requests++;
        for (int i = 0; i < 40; i++)
            send_word((i % 3 == 2) ? KIND_COUNT : KIND_READ,
                      8'($urandom_range(0, 255)), CODE_W'($urandom_range(0, 127)));
        random_items(420);

        s_tvalid = 1'b0;
        while (hist.owed_reads.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (hist.mismatches == 0 && hist.owed_reads.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ seven_bit_character_histogram_top.f @@
+incdir+design
design/sbch_pkg.sv
design/sbch_ram.sv
design/sbch_bins.sv
design/seven_bit_character_histogram_top.sv
dv/seven_bit_character_histogram_top_tb.sv
